@@ src/fbe_pkg.sv @@
// Shared types, tables and register codes for the Feistel block encryptor.
package fbe_pkg;

  localparam int HALF_W       = 16;
  localparam int BLK_W        = 32;
  localparam int KEY_W        = 24;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int RC_W         = 4;
  localparam int TABLE_ROUNDS = 10;

  localparam logic [RC_W-1:0] RC_RESET = 4'd10;

  typedef logic [3:0] nib_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUND_COUNT = 3'd0,
    REG_KEYS_0_1    = 3'd1,
    REG_KEYS_2_3    = 3'd2,
    REG_KEYS_4_5    = 3'd3,
    REG_KEYS_6_7    = 3'd4,
    REG_KEYS_8_9    = 3'd5
  } reg_idx_t;

  // One pipeline slot: a block in flight and its valid flag
  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } stage_t;

  localparam nib_t SBOX [4][16] = '{
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
    '{4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6},
    '{4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14},
    '{4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3}
  };

  localparam nib_t EXP [24] = '{
    4'd6, 4'd5, 4'd12, 4'd11, 4'd7, 4'd3, 4'd1, 4'd13, 4'd14, 4'd10, 4'd4, 4'd9,
    4'd0, 4'd5, 4'd8,  4'd14, 4'd1, 4'd6, 4'd13, 4'd15, 4'd2, 4'd7, 4'd15, 4'd2
  };

  localparam nib_t PERM [TABLE_ROUNDS][16] = '{
    '{4'd2,  4'd6,  4'd13, 4'd4,  4'd8,  4'd11, 4'd1,  4'd15,
      4'd12, 4'd14, 4'd0,  4'd5,  4'd10, 4'd3,  4'd7,  4'd9},
    '{4'd13, 4'd3,  4'd7,  4'd5,  4'd0,  4'd8,  4'd15, 4'd2,
      4'd1,  4'd11, 4'd6,  4'd4,  4'd14, 4'd10, 4'd9,  4'd12},
    '{4'd11, 4'd6,  4'd15, 4'd9,  4'd1,  4'd0,  4'd4,  4'd12,
      4'd5,  4'd2,  4'd7,  4'd10, 4'd8,  4'd13, 4'd14, 4'd3},
    '{4'd5,  4'd14, 4'd13, 4'd12, 4'd6,  4'd2,  4'd10, 4'd0,
      4'd9,  4'd11, 4'd3,  4'd1,  4'd4,  4'd7,  4'd15, 4'd8},
    '{4'd10, 4'd15, 4'd2,  4'd13, 4'd3,  4'd9,  4'd11, 4'd1,
      4'd14, 4'd7,  4'd4,  4'd8,  4'd0,  4'd12, 4'd5,  4'd6},
    '{4'd5,  4'd7,  4'd14, 4'd13, 4'd10, 4'd11, 4'd12, 4'd2,
      4'd1,  4'd3,  4'd0,  4'd15, 4'd9,  4'd6,  4'd4,  4'd8},
    '{4'd6,  4'd4,  4'd11, 4'd14, 4'd5,  4'd0,  4'd13, 4'd8,
      4'd3,  4'd15, 4'd7,  4'd10, 4'd2,  4'd9,  4'd1,  4'd12},
    '{4'd11, 4'd1,  4'd7,  4'd15, 4'd9,  4'd8,  4'd5,  4'd6,
      4'd0,  4'd2,  4'd3,  4'd4,  4'd13, 4'd14, 4'd12, 4'd10},
    '{4'd1,  4'd12, 4'd0,  4'd8,  4'd9,  4'd4,  4'd13, 4'd14,
      4'd10, 4'd2,  4'd15, 4'd7,  4'd5,  4'd11, 4'd3,  4'd6},
    '{4'd8,  4'd4,  4'd3,  4'd13, 4'd15, 4'd7,  4'd5,  4'd6,
      4'd12, 4'd0,  4'd14, 4'd11, 4'd9,  4'd10, 4'd1,  4'd2}
  };

endpackage

@@ src/fbe_round_cell.sv @@
// One Feistel round as a pipeline cell: round function and swap (pass-through when inactive), output register.
module fbe_round_cell import fbe_pkg::*; #(
  parameter int ROUND = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             active,
  input  logic [KEY_W-1:0] key,
  input  stage_t           d,
  output stage_t           q
);

  logic [KEY_W-1:0]  exp_w;
  logic [KEY_W-1:0]  x_w;
  logic [HALF_W-1:0] s_w;
  logic [HALF_W-1:0] f_w;
  stage_t            q_r;
  stage_t            q_nxt;

  always_comb begin
    for (int b = 0; b < KEY_W; b++) begin
      exp_w[b] = d.right[EXP[KEY_W-1-b]];
    end
  end

  assign x_w = exp_w ^ key;

  // row from the outer chunk bits, column from the middle four
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s_w[HALF_W-1-4*c -: 4] = SBOX[{x_w[KEY_W-1-6*c], x_w[KEY_W-6-6*c]}]
                                   [x_w[KEY_W-2-6*c -: 4]];
    end
  end

  always_comb begin
    for (int k = 0; k < HALF_W; k++) begin
      f_w[HALF_W-1-k] = s_w[PERM[ROUND][k]];
    end
  end

  always_comb begin
    q_nxt.valid = d.valid;
    if (active) begin
      q_nxt.left  = d.right;
      q_nxt.right = d.left ^ f_w;
    end else begin
      q_nxt.left  = d.left;
      q_nxt.right = d.right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.left  <= q_nxt.left;
    q_r.right <= q_nxt.right;
  end

  assign q = q_r;

endmodule

@@ src/feistel_block_encrypt_32.sv @@
// Top level: configuration registers and a chain of Feistel round cells.
//
//   channel  ports                                   request taken when
//   -------  --------------------------------------  -------------------------
//   input    start, busy, in_plain_block             start high, busy low
//   result   out_valid, out_cipher_block             out_valid high (1 cycle)
//   config   cfg_we, cfg_index, cfg_wdata            cfg_we high
//
// One block enters every cycle; busy is never raised.
// Every block passes through all MAX_ROUNDS registered round cells, whatever round_count is;
// cells past round_count pass the block through unchanged.
// Reset clears the pipeline valid flags, round_count to 10 and all keys to 0.
// The receiver cannot stall: each result shows for exactly one cycle.
module feistel_block_encrypt_32 import fbe_pkg::*; #(
  parameter int MAX_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [BLK_W-1:0]     in_plain_block,
  output logic                 out_valid,
  output logic [BLK_W-1:0]     out_cipher_block,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [RC_W-1:0]  round_count_r;
  logic [RC_W-1:0]  round_count_nxt;
  logic [KEY_W-1:0] key_r   [TABLE_ROUNDS];
  logic [KEY_W-1:0] key_nxt [TABLE_ROUNDS];
  logic [RC_W-1:0]  eff_rounds;
  logic [MAX_ROUNDS-1:0] cell_active;
  stage_t           pipe [MAX_ROUNDS+1];

  // configuration writes
  always_comb begin
    round_count_nxt = round_count_r;
    key_nxt         = key_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROUND_COUNT: round_count_nxt = cfg_wdata[RC_W-1:0];
        REG_KEYS_0_1: begin
          key_nxt[0] = cfg_wdata[KEY_W-1:0];
          key_nxt[1] = cfg_wdata[2*KEY_W-1:KEY_W];
        end
        REG_KEYS_2_3: begin
          key_nxt[2] = cfg_wdata[KEY_W-1:0];
          key_nxt[3] = cfg_wdata[2*KEY_W-1:KEY_W];
        end
        REG_KEYS_4_5: begin
          key_nxt[4] = cfg_wdata[KEY_W-1:0];
          key_nxt[5] = cfg_wdata[2*KEY_W-1:KEY_W];
        end
        REG_KEYS_6_7: begin
          key_nxt[6] = cfg_wdata[KEY_W-1:0];
          key_nxt[7] = cfg_wdata[2*KEY_W-1:KEY_W];
        end
        REG_KEYS_8_9: begin
          key_nxt[8] = cfg_wdata[KEY_W-1:0];
          key_nxt[9] = cfg_wdata[2*KEY_W-1:KEY_W];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RC_RESET;
      for (int i = 0; i < TABLE_ROUNDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      round_count_r <= round_count_nxt;
      key_r         <= key_nxt;
    end
  end

  // counts above the cell chain saturate
  assign eff_rounds = (round_count_r > RC_W'(MAX_ROUNDS)) ? RC_W'(MAX_ROUNDS)
                                                          : round_count_r;

  assign busy = 1'b0;

  assign pipe[0].valid = start;
  assign pipe[0].left  = in_plain_block[BLK_W-1:HALF_W];
  assign pipe[0].right = in_plain_block[HALF_W-1:0];

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_cell
    assign cell_active[i] = RC_W'(i) < eff_rounds;

    fbe_round_cell #(
      .ROUND (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .active (cell_active[i]),
      .key    (key_r[i]),
      .d      (pipe[i]),
      .q      (pipe[i+1])
    );
  end

  assign out_valid        = pipe[MAX_ROUNDS].valid;
  assign out_cipher_block = {pipe[MAX_ROUNDS].left, pipe[MAX_ROUNDS].right};

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0)
    else $error("busy raised");

  a_enter_chain: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> pipe[1].valid)
    else $error("accepted block missing from first cell");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !pipe[1].valid)
    else $error("first cell valid without a request");

  a_last_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe[MAX_ROUNDS-1].valid && !cell_active[MAX_ROUNDS-1]) |=>
      (out_valid && out_cipher_block ==
        $past({pipe[MAX_ROUNDS-1].left, pipe[MAX_ROUNDS-1].right})))
    else $error("inactive last round altered the block");

endmodule
